// File: sv/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types and constants for the two-stacks-in-one-array block: field
// widths, opcodes, status codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tsa_pkg;

    // field widths
    localparam int OPCODE_W = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 5;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH1 = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH2 = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP1  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP2  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PEEK1 = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_PEEK2 = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;      // capture the input word
        logic exec;         // apply the operation to store and counts
        logic load_direct;  // result word computed without a store read
        logic load_mem;     // result word taken from the store read data
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic needs_read;   // operation reads a word from the store
        logic out_free;     // output register can take a result word
    } sts_t;

endpackage

`default_nettype wire

// File: sv/two_stacks_shared_array.sv
// ----------------------------------------------------------------------------
// two_stacks_shared_array
// Two stacks in one store: stack one grows up from slot 0, stack two grows
// down from the top of the capacity in use. Push, pop and peek per word.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_opcode, s_push_value
//   m_       out        m_valid/m_ready    m_read_value, m_status
//   cfg_     in         cfg_we             cfg_wdata (capacity_in_use)
//
// One word at a time: a push, an unused opcode or an empty pop/peek passes
// through the capture and execute states, its result registered in the execute
// state; a pop or peek that reads the store adds a read state, set by the
// registered read port of the store, and its result is registered there.
// While a result waits for m_ready one more word is taken, then s_ready stalls.
// Synchronous reset: counts cleared, capacity 16; a capacity write empties both stacks.
// ----------------------------------------------------------------------------
`default_nettype none

module two_stacks_shared_array #(
    parameter int DEPTH = 16
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_we,
    input  wire        [tsa_pkg::CAP_W-1:0]      cfg_wdata,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire        [tsa_pkg::OPCODE_W-1:0]   s_opcode,
    input  wire signed [tsa_pkg::DATA_W-1:0]     s_push_value,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [tsa_pkg::DATA_W-1:0]    m_read_value,
    output logic       [tsa_pkg::STATUS_W-1:0]   m_status
);

    tsa_pkg::cmd_t cmd;
    tsa_pkg::sts_t sts;

    // sequencer
    tsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // store, counts and output register
    tsa_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_opcode     (s_opcode),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status)
    );

endmodule

`default_nettype wire

// File: sv/tsa_datapath.sv
// ----------------------------------------------------------------------------
// tsa_datapath
// Input register, capacity register, stack counts, shared store with a
// registered read port and the output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_datapath #(
    parameter int DEPTH = 16
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  tsa_pkg::cmd_t                       cmd,
    output tsa_pkg::sts_t                       sts,
    input  wire                                 cfg_we,
    input  wire        [tsa_pkg::CAP_W-1:0]     cfg_wdata,
    input  wire        [tsa_pkg::OPCODE_W-1:0]  s_opcode,
    input  wire signed [tsa_pkg::DATA_W-1:0]    s_push_value,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic signed [tsa_pkg::DATA_W-1:0]   m_read_value,
    output logic       [tsa_pkg::STATUS_W-1:0]  m_status
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = ((CNT_W > tsa_pkg::CAP_W) ? CNT_W : tsa_pkg::CAP_W) + 1;

    logic        [tsa_pkg::OPCODE_W-1:0] op_reg;
    logic signed [tsa_pkg::DATA_W-1:0]   value_reg;
    logic        [tsa_pkg::CAP_W-1:0]    cap_reg;
    logic        [CNT_W-1:0]             lower_reg, lower_next;
    logic        [CNT_W-1:0]             upper_reg, upper_next;
    logic        [tsa_pkg::DATA_W-1:0]   mem [DEPTH];
    logic        [tsa_pkg::DATA_W-1:0]   rd_data_reg;
    logic                                m_valid_reg;
    logic signed [tsa_pkg::DATA_W-1:0]   out_value_reg;
    logic        [tsa_pkg::STATUS_W-1:0] out_status_reg;

    logic                                is_push, is_rd, is_pop, one;
    logic        [EXT_W-1:0]             cap_ext, depth_ext, cap_eff_ext;
    logic        [CNT_W-1:0]             cap_eff, cnt_sel;
    logic        [CNT_W:0]               used;
    logic                                full, empty;
    logic        [CNT_W-1:0]             push_slot, read_slot;
    logic        [AW-1:0]                addr;
    logic                                mem_we, mem_re;
    logic signed [tsa_pkg::DATA_W-1:0]   direct_value;
    logic        [tsa_pkg::STATUS_W-1:0] direct_status;

    // opcode decode
    assign is_push = (op_reg == tsa_pkg::OP_PUSH1) || (op_reg == tsa_pkg::OP_PUSH2);
    assign is_pop  = (op_reg == tsa_pkg::OP_POP1)  || (op_reg == tsa_pkg::OP_POP2);
    assign is_rd   = is_pop || (op_reg == tsa_pkg::OP_PEEK1) ||
                     (op_reg == tsa_pkg::OP_PEEK2);
    assign one     = ~op_reg[0];

    // effective capacity saturates at the store depth
    assign cap_ext     = EXT_W'(cap_reg);
    assign depth_ext   = EXT_W'(DEPTH);
    assign cap_eff_ext = (cap_ext > depth_ext) ? depth_ext : cap_ext;
    assign cap_eff     = cap_eff_ext[CNT_W-1:0];

    // full and empty checks
    assign used    = {1'b0, lower_reg} + {1'b0, upper_reg};
    assign full    = used >= {1'b0, cap_eff};
    assign cnt_sel = one ? lower_reg : upper_reg;
    assign empty   = (cnt_sel == '0) || (cnt_sel > cap_eff);

    // slot addresses: stack one from the bottom, stack two from the top
    assign push_slot = one ? lower_reg : (cap_eff - upper_reg - CNT_W'(1));
    assign read_slot = one ? (cnt_sel - CNT_W'(1)) : (cap_eff - cnt_sel);
    assign addr      = is_push ? push_slot[AW-1:0] : read_slot[AW-1:0];

    assign mem_we = cmd.exec && is_push && !full;
    assign mem_re = cmd.exec && is_rd && !empty;

    // status back to the controller
    assign sts = '{needs_read: is_rd && !empty, out_free: !m_valid_reg || m_ready};

    // result word without a store read
    always_comb begin
        direct_value  = '0;
        direct_status = tsa_pkg::ST_OK;
        if (is_push && full) begin
            direct_status = tsa_pkg::ST_OVERFLOW;
        end else if (is_rd) begin
            direct_value  = '1;
            direct_status = tsa_pkg::ST_EMPTY;
        end
    end

    // count updates
    always_comb begin
        lower_next = lower_reg;
        upper_next = upper_reg;
        if (cfg_we) begin
            lower_next = '0;
            upper_next = '0;
        end else if (cmd.exec) begin
            if (is_push && !full) begin
                if (one) begin
                    lower_next = lower_reg + CNT_W'(1);
                end else begin
                    upper_next = upper_reg + CNT_W'(1);
                end
            end else if (is_pop && !empty) begin
                if (one) begin
                    lower_next = lower_reg - CNT_W'(1);
                end else begin
                    upper_next = upper_reg - CNT_W'(1);
                end
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= tsa_pkg::CAP_RESET;
            lower_reg   <= '0;
            upper_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            if (cmd.load_direct || cmd.load_mem) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // input word register
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg    <= s_opcode;
            value_reg <= s_push_value;
        end
    end

    // shared store, one write or one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr] <= value_reg;
        end
        if (mem_re) begin
            rd_data_reg <= mem[addr];
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (cmd.load_direct) begin
            out_value_reg  <= direct_value;
            out_status_reg <= direct_status;
        end else if (cmd.load_mem) begin
            out_value_reg  <= rd_data_reg;
            out_status_reg <= tsa_pkg::ST_OK;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = out_value_reg;
    assign m_status     = out_status_reg;

endmodule

`default_nettype wire

// File: sv/tsa_ctrl.sv
// ----------------------------------------------------------------------------
// tsa_ctrl
// Sequencer for one word at a time: capture, execute, optional store read,
// then hand the result to the output register when it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_ctrl (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           s_valid,
    output logic          s_ready,
    input  tsa_pkg::sts_t sts,
    output tsa_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    state_t state_reg, state_next;

    // command decode
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.needs_read) begin
                    cmd.exec   = 1'b1;
                    state_next = S_READ;
                end else if (sts.out_free) begin
                    cmd.exec        = 1'b1;
                    cmd.load_direct = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_READ: begin
                if (sts.out_free) begin
                    cmd.load_mem = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

// File: sv/tsa_checker.sv
// ----------------------------------------------------------------------------
// tsa_checker
// Port-level checks for two_stacks_shared_array, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_checker (
    input wire                                 aclk,
    input wire                                 aresetn,
    input wire                                 s_valid,
    input wire                                 s_ready,
    input wire                                 m_valid,
    input wire                                 m_ready,
    input wire signed [tsa_pkg::DATA_W-1:0]    m_read_value,
    input wire        [tsa_pkg::STATUS_W-1:0]  m_status
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_value) && $stable(m_status))
        else $error("result word changed while stalled");

    // empty result carries all ones
    a_empty_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == tsa_pkg::ST_EMPTY) |-> (m_read_value == -32'sd1))
        else $error("empty result without -1");

    // overflow result carries zero
    a_ovf_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == tsa_pkg::ST_OVERFLOW) |-> (m_read_value == 32'sd0))
        else $error("overflow result with nonzero data");

    // one word in flight: ready drops after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted back to back");

endmodule

bind two_stacks_shared_array tsa_checker u_tsa_checker (.*);

`default_nettype wire

// File: test/two_stacks_shared_array_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stacks_shared_array_test
// Self-checking bench for the two-stacks-in-one-array block. A scoreboard
// class tracks both stacks and the capacity, predicts read value and status
// for every accepted word and checks each result in order. The stimulus
// starts with directed corner cases: empty stacks, extreme values, the
// meeting point of the stacks, zero capacity and unused opcodes. It then
// runs random phases at several capacities, saturated among them. Both sides
// insert random gaps, and one long output hold backs up the input.
// ----------------------------------------------------------------------------

module two_stacks_shared_array_test;

    localparam int STORE_DEPTH  = 16;
    localparam int TIMEOUT_NS   = 20_000_000;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE       = 6;
    localparam int PHASES       = 12;
    localparam int PHASE_WORDS  = 160;
    localparam int MAX_PRINTS   = 40;

    // opcodes the block leaves without effect
    localparam logic [tsa_pkg::OPCODE_W-1:0] OP_UNUSED_LO = 3'd6;
    localparam logic [tsa_pkg::OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [tsa_pkg::DATA_W-1:0]   read_value;
        logic [tsa_pkg::STATUS_W-1:0] status;
    } stack_result_t;

    // tracks both stacks and holds the results still to come
    class stack_board;
        logic [tsa_pkg::DATA_W-1:0] slot_words [STORE_DEPTH];
        int                lower_count;
        int                upper_count;
        int                capacity;
        stack_result_t     expected_words [$];
        int                mismatches;
        int                words_in;
        int                results_seen;
        int                ok_seen;
        int                overflow_seen;
        int                empty_seen;

        function new();
            capacity     = int'(tsa_pkg::CAP_RESET);
            lower_count  = 0;
            upper_count  = 0;
            mismatches   = 0;
            words_in     = 0;
            results_seen = 0;
        endfunction

        // a capacity write empties both stacks
        function void set_capacity(int value);
            capacity    = value;
            lower_count = 0;
            upper_count = 0;
        endfunction

        function int outstanding();
            return expected_words.size();
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("%0t mismatch: %s", $realtime, what);
        endtask

        // predict the result of one accepted word
        function void note_input(logic [tsa_pkg::OPCODE_W-1:0] op,
                                 logic [tsa_pkg::DATA_W-1:0] word);
            stack_result_t r;
            int            limit;
            int            depth_now;
            logic          on_lower;
            limit        = (capacity > STORE_DEPTH) ? STORE_DEPTH : capacity;
            on_lower     = (op == tsa_pkg::OP_PUSH1) || (op == tsa_pkg::OP_POP1) ||
                           (op == tsa_pkg::OP_PEEK1);
            r.read_value = '0;
            r.status     = tsa_pkg::ST_OK;
            case (op) inside
                tsa_pkg::OP_PUSH1, tsa_pkg::OP_PUSH2: begin
                    if (lower_count + upper_count >= limit) begin
                        r.status = tsa_pkg::ST_OVERFLOW;
                    end else if (on_lower) begin
                        slot_words[lower_count] = word;
                        lower_count++;
                    end else begin
                        upper_count++;
                        slot_words[limit - upper_count] = word;
                    end
                end
                tsa_pkg::OP_POP1, tsa_pkg::OP_POP2,
                tsa_pkg::OP_PEEK1, tsa_pkg::OP_PEEK2: begin
                    depth_now = on_lower ? lower_count : upper_count;
                    if (depth_now == 0) begin
                        r.read_value = '1;
                        r.status     = tsa_pkg::ST_EMPTY;
                    end else begin
                        r.read_value = on_lower ? slot_words[depth_now - 1]
                                                : slot_words[limit - depth_now];
                        if (op == tsa_pkg::OP_POP1)
                            lower_count--;
                        else if (op == tsa_pkg::OP_POP2)
                            upper_count--;
                    end
                end
                default: ;
            endcase
            words_in++;
            expected_words.push_back(r);
        endfunction

        // compare one result word with the oldest prediction
        task check_result(logic [tsa_pkg::DATA_W-1:0] value,
                          logic [tsa_pkg::STATUS_W-1:0] status);
            stack_result_t e;
            results_seen++;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("result %08h/%0d with nothing expected",
                                          value, status));
            end else begin
                e = expected_words.pop_front();
                if (value !== e.read_value)
                    report_mismatch($sformatf("read_value %08h, expected %08h",
                                              value, e.read_value));
                if (status !== e.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, e.status));
                case (e.status)
                    tsa_pkg::ST_OVERFLOW: overflow_seen++;
                    tsa_pkg::ST_EMPTY:    empty_seen++;
                    default:              ok_seen++;
                endcase
            end
        endtask
    endclass

    logic                                 aclk         = 1'b0;
    logic                                 aresetn      = 1'b0;
    logic                                 cfg_we       = 1'b0;
    logic [tsa_pkg::CAP_W-1:0]            cfg_wdata    = '0;
    logic                                 s_valid      = 1'b0;
    logic                                 s_ready;
    logic [tsa_pkg::OPCODE_W-1:0]         s_opcode     = '0;
    logic signed [tsa_pkg::DATA_W-1:0]    s_push_value = '0;
    logic                                 m_valid;
    logic                                 m_ready      = 1'b0;
    logic signed [tsa_pkg::DATA_W-1:0]    m_read_value;
    logic [tsa_pkg::STATUS_W-1:0]         m_status;

    stack_board board = new();
    logic       steady       = 1'b0;
    logic       hold_request = 1'b0;
    logic       hold_done    = 1'b0;
    int         ready_gap    = 0;
    int         cap_writes   = 0;

    two_stacks_shared_array #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic logic [tsa_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // opcode mix: push share and stack-one share set per phase
    function automatic logic [tsa_pkg::OPCODE_W-1:0] pick_opcode(int push_pct,
                                                                 int lower_pct);
        int   r;
        logic on_lower;
        r        = $urandom_range(99);
        on_lower = ($urandom_range(99) < lower_pct);
        if (r < 3)
            return $urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO;
        if (r < 3 + push_pct)
            return on_lower ? tsa_pkg::OP_PUSH1 : tsa_pkg::OP_PUSH2;
        if ($urandom_range(99) < 70)
            return on_lower ? tsa_pkg::OP_POP1 : tsa_pkg::OP_POP2;
        return on_lower ? tsa_pkg::OP_PEEK1 : tsa_pkg::OP_PEEK2;
    endfunction

    // offer one word and wait for its handshake
    task automatic send_word(logic [tsa_pkg::OPCODE_W-1:0] op,
                             logic [tsa_pkg::DATA_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_push_value <= value;
        do @(posedge aclk); while (!s_ready);
        board.note_input(op, value);
    endtask

    // stop offering and wait until every predicted result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // capacity write while the block is idle
    task automatic write_capacity(int value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[tsa_pkg::CAP_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        board.set_capacity(value);
        cap_writes++;
    endtask

    // result side: check accepted words, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_read_value, m_status);
        if (hold_request && !hold_done) begin
            ready_gap = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (ready_gap > 0) begin
            m_ready <= 1'b0;
            ready_gap--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(3) == 0)
                ready_gap = pick_gap();
        end
    end

    // stimulus
    initial begin
        int caps [PHASES];
        int lean;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty stacks, extreme words, unused opcodes at full capacity
        send_word(tsa_pkg::OP_PEEK1, 32'h0000_0001);
        send_word(tsa_pkg::OP_PEEK2, 32'h0000_0002);
        send_word(tsa_pkg::OP_POP1,  32'hFFFF_FFFF);
        send_word(tsa_pkg::OP_POP2,  32'h0000_0000);
        send_word(tsa_pkg::OP_PUSH1, 32'h7FFF_FFFF);
        send_word(tsa_pkg::OP_PUSH2, 32'h8000_0000);
        send_word(tsa_pkg::OP_PEEK1, 32'h0000_0000);
        send_word(tsa_pkg::OP_PEEK2, 32'h0000_0000);
        send_word(tsa_pkg::OP_PUSH1, 32'hFFFF_FFFF);
        send_word(tsa_pkg::OP_PUSH2, 32'h0000_0000);
        send_word(tsa_pkg::OP_POP1,  32'h0000_0000);
        send_word(tsa_pkg::OP_POP2,  32'h0000_0000);
        send_word(tsa_pkg::OP_POP1,  32'h0000_0000);
        send_word(tsa_pkg::OP_POP2,  32'h0000_0000);
        send_word(OP_UNUSED_LO, 32'hFFFF_FFFF);
        send_word(OP_UNUSED_HI, 32'h1234_5678);

        // two slots: the stacks meet and further pushes overflow
        write_capacity(2);
        send_word(tsa_pkg::OP_PUSH1, 32'hA5A5_A5A5);
        send_word(tsa_pkg::OP_PUSH2, 32'h5A5A_5A5A);
        send_word(tsa_pkg::OP_PUSH1, 32'hDEAD_BEEF);
        send_word(tsa_pkg::OP_PUSH2, 32'hCAFE_F00D);
        send_word(tsa_pkg::OP_PEEK2, 32'h0000_0000);
        send_word(tsa_pkg::OP_POP1,  32'h0000_0000);

        // zero capacity: nothing fits, nothing to read
        write_capacity(0);
        send_word(tsa_pkg::OP_PUSH2, 32'h0F0F_0F0F);
        send_word(tsa_pkg::OP_POP1,  32'h0000_0000);
        send_word(tsa_pkg::OP_PEEK2, 32'h0000_0000);

        // random phases, from saturated capacity down to zero
        caps = '{31, 1, 5, 16, 3, 17, 8, 0, 2, 0, 12, 16};
        caps[9] = $urandom_range(15, 1);
        for (int p = 0; p < PHASES; p++) begin
            write_capacity(caps[p]);
            steady = (p % 4 == 2);
            lean   = (p % 5 == 4) ? 90 : $urandom_range(80, 20);
            if (p == 3)
                hold_request <= 1'b1;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (i == PHASE_WORDS / 2 && p % 3 == 1)
                    lean = 100 - lean;
                send_word(pick_opcode((i < PHASE_WORDS / 2) ? 70 : 30, lean),
                          pick_value());
            end
        end

        steady = 1'b0;
        drain_results();
        $display("%0d words checked over %0d capacity settings: %0d ok, %0d overflow, %0d empty",
                 board.words_in, cap_writes + 1, board.ok_seen, board.overflow_seen,
                 board.empty_seen);
        $display("stall pressure: one %0d-cycle output hold, random gaps on both sides",
                 HOLD_CYCLES);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("PASS two_stacks_shared_array");
        else
            $display("FAIL two_stacks_shared_array");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", board.outstanding());
        $display("FAIL two_stacks_shared_array");
        $finish;
    end

endmodule

// File: two_stacks_shared_array.f
sv/tsa_pkg.sv
sv/tsa_datapath.sv
sv/tsa_ctrl.sv
sv/two_stacks_shared_array.sv
sv/tsa_checker.sv
test/two_stacks_shared_array_test.sv
